// ===== hw/rtl/afr_pkg.sv =====
`default_nettype none

package afr_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int COUNT_BITS = 16;

  localparam int CHAN_W  = 8;
  localparam int ARGB_W  = 4 * CHAN_W;
  localparam int DUR_W   = 16;
  localparam int PCT_W   = 7;
  localparam int LEVEL_W = CHAN_W + FRAC_BITS;
  localparam int STEP_W  = LEVEL_W + 1;
  localparam int SUM_W   = LEVEL_W + 2;
  localparam int PROD_W  = COUNT_BITS + PCT_W;
  localparam int DIV_W   = (LEVEL_W > PROD_W) ? LEVEL_W : PROD_W;
  localparam int DCNT_W  = $clog2(DIV_W + 1);

  localparam logic [PCT_W-1:0] PCT_FULL = PCT_W'(100);
  localparam logic [LEVEL_W-1:0] LEVEL_MAX = {8'hFF, {FRAC_BITS{1'b0}}};

  typedef enum logic [1:0] {
    REG_DURATION = 2'd0,
    REG_START    = 2'd1,
    REG_TARGET   = 2'd2,
    REG_NONE     = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_TICK,
    ST_STEP_GO,
    ST_STEP_WAIT,
    ST_PCT_GO,
    ST_PCT_WAIT,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic       load;
    logic       tick;
    logic       div_go;
    logic       div_pct;
    logic       store_step;
    logic       store_pct;
    logic [1:0] ch;
  } cmd_t;

  typedef struct packed {
    logic div_done;
  } status_t;

  function automatic logic [CHAN_W-1:0] chan_of(input logic [ARGB_W-1:0] argb,
                                                input logic [1:0] ch);
    chan_of = argb[{~ch, 3'b000} +: CHAN_W];
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/argb_linear_fade_ramp.sv =====
// ARGB linear fade ramp.
// Input channel: in_valid/in_stall, one bit per beat. in_start_fade = 1 latches
// the duration and target, loads the start color and arms the fade; 0 is one
// frame tick that steps each channel toward the target, snapping on the last frame.
// Result channel: out_valid/out_stall, one beat per input beat with the color,
// visible, fading and progress in percent.
// Configuration: cfg_we writes cfg_wdata to register cfg_index (0 duration,
// 1 start color, 2 target color). The user must write only while the block is
// idle; the block itself does not enforce this. One item at a time: each result
// waits on the shared restoring divider, one quotient bit per cycle, with one
// division for progress on a tick, four per-channel step divisions plus progress
// on a start. The next beat can be taken in the cycle after the result beat is
// taken.
// in_stall is high from the accepting edge until the result beat is taken.
// While out_stall is high the result holds and no new beat is accepted.
// Reset (rst_n low, synchronous) clears registers, color, counter and flags.
`default_nettype none

module argb_linear_fade_ramp (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic                        in_start_fade,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [afr_pkg::CHAN_W-1:0]       out_alpha_out,
  output logic [afr_pkg::CHAN_W-1:0]       out_red_out,
  output logic [afr_pkg::CHAN_W-1:0]       out_green_out,
  output logic [afr_pkg::CHAN_W-1:0]       out_blue_out,
  output logic                             out_visible,
  output logic                             out_fading,
  output logic [afr_pkg::PCT_W-1:0]        out_progress_percent,
  input  wire logic                        cfg_we,
  input  wire logic [1:0]                  cfg_index,
  input  wire logic [afr_pkg::ARGB_W-1:0]  cfg_wdata
);
  import afr_pkg::*;

  cmd_t    cmd;
  status_t status;

  afr_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_start_fade (in_start_fade),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .cmd           (cmd),
    .status        (status)
  );

  afr_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .status           (status),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .alpha_out        (out_alpha_out),
    .red_out          (out_red_out),
    .green_out        (out_green_out),
    .blue_out         (out_blue_out),
    .visible          (out_visible),
    .fading           (out_fading),
    .progress_percent (out_progress_percent)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/afr_div.sv =====
`default_nettype none

module afr_div (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          go,
  input  wire logic [afr_pkg::DIV_W-1:0]     dividend,
  input  wire logic [afr_pkg::COUNT_BITS-1:0] divisor,
  output logic                               done,
  output logic [afr_pkg::DIV_W-1:0]          quotient
);
  import afr_pkg::*;

  logic                  busy_r;
  logic                  done_r;
  logic [DCNT_W-1:0]     cnt_r;
  logic [DIV_W-1:0]      quo_r;
  logic [COUNT_BITS-1:0] rem_r;
  logic [COUNT_BITS-1:0] dsr_r;
  logic [COUNT_BITS:0]   trial;
  logic                  fits;

  assign trial = {rem_r, quo_r[DIV_W-1]};
  assign fits  = trial >= {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        busy_r <= 1'b1;
        cnt_r  <= DCNT_W'(DIV_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DCNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      quo_r <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DIV_W-2:0], fits};
      if (fits) begin
        rem_r <= COUNT_BITS'(trial - {1'b0, dsr_r});
      end else begin
        rem_r <= trial[COUNT_BITS-1:0];
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

// ===== hw/rtl/afr_dp.sv =====
`default_nettype none

module afr_dp (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire afr_pkg::cmd_t               cmd,
  output afr_pkg::status_t                 status,
  input  wire logic                        cfg_we,
  input  wire logic [1:0]                  cfg_index,
  input  wire logic [afr_pkg::ARGB_W-1:0]  cfg_wdata,
  output logic [afr_pkg::CHAN_W-1:0]       alpha_out,
  output logic [afr_pkg::CHAN_W-1:0]       red_out,
  output logic [afr_pkg::CHAN_W-1:0]       green_out,
  output logic [afr_pkg::CHAN_W-1:0]       blue_out,
  output logic                             visible,
  output logic                             fading,
  output logic [afr_pkg::PCT_W-1:0]        progress_percent
);
  import afr_pkg::*;

  logic [DUR_W-1:0]        duration_r;
  logic [ARGB_W-1:0]       start_argb_r;
  logic [ARGB_W-1:0]       target_argb_r;

  logic                    armed_r;
  logic                    running_r;
  logic [COUNT_BITS-1:0]   fc_r;
  logic [COUNT_BITS-1:0]   fade_len_r;
  logic [ARGB_W-1:0]       end_color_r;
  logic [LEVEL_W-1:0]      level_r [4];
  logic signed [STEP_W-1:0] step_r [4];
  logic [PCT_W-1:0]        pct_r;

  logic [LEVEL_W-1:0]      level_nxt [4];
  logic [COUNT_BITS-1:0]   fc_nxt;
  logic                    running_nxt;
  logic [COUNT_BITS:0]     fc_inc;
  logic                    snap;

  logic [CHAN_W-1:0]       from_c;
  logic [CHAN_W-1:0]       to_c;
  logic                    neg;
  logic [CHAN_W-1:0]       mag;
  logic [DIV_W-1:0]        dividend;
  logic                    div_done;
  logic [DIV_W-1:0]        quotient;
  logic signed [STEP_W-1:0] step_val;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      duration_r    <= '0;
      start_argb_r  <= '0;
      target_argb_r <= '0;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_DURATION: duration_r    <= cfg_wdata[DUR_W-1:0];
        REG_START:    start_argb_r  <= cfg_wdata;
        REG_TARGET:   target_argb_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign from_c = level_r[cmd.ch][LEVEL_W-1:FRAC_BITS];
  assign to_c   = chan_of(end_color_r, cmd.ch);
  assign neg    = to_c < from_c;
  assign mag    = neg ? (from_c - to_c) : (to_c - from_c);

  always_comb begin
    if (cmd.div_pct) begin
      dividend = DIV_W'(PROD_W'(fc_r) * PROD_W'(PCT_FULL));
    end else begin
      dividend = DIV_W'({mag, {FRAC_BITS{1'b0}}});
    end
  end

  afr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (cmd.div_go),
    .dividend (dividend),
    .divisor  (fade_len_r),
    .done     (div_done),
    .quotient (quotient)
  );

  assign status.div_done = div_done;

  always_comb begin
    step_val = $signed({1'b0, quotient[LEVEL_W-1:0]});
    if (fade_len_r == '0) begin
      step_val = '0;
    end else if (neg) begin
      step_val = -$signed({1'b0, quotient[LEVEL_W-1:0]});
    end
  end

  always_comb begin
    fc_inc      = {1'b0, fc_r} + 1'b1;
    fc_nxt      = fc_r;
    running_nxt = running_r;
    if (running_r) begin
      if (fc_inc >= {1'b0, fade_len_r}) begin
        fc_nxt      = fade_len_r;
        running_nxt = 1'b0;
      end else begin
        fc_nxt = fc_inc[COUNT_BITS-1:0];
      end
    end
    snap = fc_nxt == fade_len_r;
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      logic signed [SUM_W-1:0] v;
      if (snap) begin
        v = $signed({2'b00, chan_of(end_color_r, 2'(i)), {FRAC_BITS{1'b0}}});
      end else begin
        v = $signed({2'b00, level_r[i]}) + SUM_W'(step_r[i]);
      end
      if (v < 0) begin
        level_nxt[i] = '0;
      end else if (v > $signed({2'b00, LEVEL_MAX})) begin
        level_nxt[i] = LEVEL_MAX;
      end else begin
        level_nxt[i] = v[LEVEL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r     <= 1'b0;
      running_r   <= 1'b0;
      fc_r        <= '0;
      fade_len_r  <= '0;
      end_color_r <= '0;
      pct_r       <= '0;
      for (int i = 0; i < 4; i++) begin
        level_r[i] <= '0;
        step_r[i]  <= '0;
      end
    end else begin
      if (cmd.load) begin
        armed_r     <= 1'b1;
        running_r   <= 1'b1;
        fc_r        <= '0;
        fade_len_r  <= COUNT_BITS'(duration_r);
        end_color_r <= target_argb_r;
        for (int i = 0; i < 4; i++) begin
          level_r[i] <= {chan_of(start_argb_r, 2'(i)), {FRAC_BITS{1'b0}}};
        end
      end else if (cmd.tick && armed_r) begin
        running_r <= running_nxt;
        fc_r      <= fc_nxt;
        for (int i = 0; i < 4; i++) begin
          level_r[i] <= level_nxt[i];
        end
      end
      if (cmd.store_step) begin
        step_r[cmd.ch] <= step_val;
      end
      if (cmd.store_pct) begin
        pct_r <= (fade_len_r == '0) ? PCT_FULL : quotient[PCT_W-1:0];
      end
    end
  end

  assign alpha_out        = level_r[0][LEVEL_W-1:FRAC_BITS];
  assign red_out          = level_r[1][LEVEL_W-1:FRAC_BITS];
  assign green_out        = level_r[2][LEVEL_W-1:FRAC_BITS];
  assign blue_out         = level_r[3][LEVEL_W-1:FRAC_BITS];
  assign visible          = armed_r;
  assign fading           = running_r;
  assign progress_percent = pct_r;

endmodule

`default_nettype wire

// ===== hw/rtl/afr_ctrl.sv =====
`default_nettype none

module afr_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              in_start_fade,
  output logic                   in_stall,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output afr_pkg::cmd_t          cmd,
  input  wire afr_pkg::status_t  status
);
  import afr_pkg::*;

  state_t     state_r;
  state_t     state_nxt;
  logic [1:0] ch_r;
  logic [1:0] ch_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ch_r    <= '0;
    end else begin
      state_r <= state_nxt;
      ch_r    <= ch_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ch_nxt    = ch_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = in_start_fade ? ST_LOAD : ST_TICK;
        end
      end
      ST_LOAD: begin
        ch_nxt    = '0;
        state_nxt = ST_STEP_GO;
      end
      ST_TICK:    state_nxt = ST_PCT_GO;
      ST_STEP_GO: state_nxt = ST_STEP_WAIT;
      ST_STEP_WAIT: begin
        if (status.div_done) begin
          ch_nxt    = ch_r + 1'b1;
          state_nxt = (ch_r == 2'd3) ? ST_PCT_GO : ST_STEP_GO;
        end
      end
      ST_PCT_GO: state_nxt = ST_PCT_WAIT;
      ST_PCT_WAIT: begin
        if (status.div_done) begin
          state_nxt = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (!out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd            = '0;
    cmd.ch         = ch_r;
    cmd.load       = state_r == ST_LOAD;
    cmd.tick       = state_r == ST_TICK;
    cmd.div_go     = (state_r == ST_STEP_GO) || (state_r == ST_PCT_GO);
    cmd.div_pct    = (state_r == ST_PCT_GO) || (state_r == ST_PCT_WAIT);
    cmd.store_step = (state_r == ST_STEP_WAIT) && status.div_done;
    cmd.store_pct  = (state_r == ST_PCT_WAIT) && status.div_done;
    in_stall       = state_r != ST_IDLE;
    out_valid      = state_r == ST_RESULT;
  end

endmodule

`default_nettype wire

// ===== bench/fade_monitor.sv =====
`default_nettype none

module fade_monitor (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  input  wire logic                        in_stall,
  input  wire logic                        in_start_fade,
  input  wire logic                        out_valid,
  input  wire logic                        out_stall,
  input  wire logic [afr_pkg::CHAN_W-1:0]  out_alpha_out,
  input  wire logic [afr_pkg::CHAN_W-1:0]  out_red_out,
  input  wire logic [afr_pkg::CHAN_W-1:0]  out_green_out,
  input  wire logic [afr_pkg::CHAN_W-1:0]  out_blue_out,
  input  wire logic                        out_visible,
  input  wire logic                        out_fading,
  input  wire logic [afr_pkg::PCT_W-1:0]   out_progress_percent,
  input  wire logic                        cfg_we,
  input  wire logic [1:0]                  cfg_index,
  input  wire logic [afr_pkg::ARGB_W-1:0]  cfg_wdata,
  output int                               fail_count,
  output int                               due_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import afr_pkg::*;

  typedef struct packed {
    logic [CHAN_W-1:0] alpha;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic              visible;
    logic              fading;
    logic [PCT_W-1:0]  percent;
  } fade_view_t;

  logic [DUR_W-1:0]             dur_reg;
  logic [ARGB_W-1:0]            start_reg;
  logic [ARGB_W-1:0]            target_reg;
  logic [COUNT_BITS-1:0]        frame_cnt;
  logic [COUNT_BITS-1:0]        span;
  logic [ARGB_W-1:0]            end_rgb;
  bit                           armed;
  bit                           running;
  logic [LEVEL_W-1:0]           level [4];
  logic signed [STEP_W-1:0]     step [4];
  fade_view_t                   due_views [$];
  int                           fails = 0;

  assign fail_count = fails;

  task automatic advance_fade(input logic start_bit, output fade_view_t view);
    logic [COUNT_BITS:0]      nxt;
    logic signed [SUM_W-1:0]  sum;
    logic [CHAN_W-1:0]        from_c;
    logic [CHAN_W-1:0]        to_c;
    logic [LEVEL_W-1:0]       mag;
    logic [31:0]              pct;
    if (start_bit) begin
      armed = 1'b1;
      running = 1'b1;
      frame_cnt = '0;
      span = COUNT_BITS'(dur_reg);
      end_rgb = target_reg;
      for (int i = 0; i < 4; i++) begin
        from_c = start_reg[CHAN_W*(3-i) +: CHAN_W];
        to_c = target_reg[CHAN_W*(3-i) +: CHAN_W];
        level[i] = {from_c, {FRAC_BITS{1'b0}}};
        if (span == 0) begin
          step[i] = '0;
        end else if (to_c >= from_c) begin
          mag = {to_c - from_c, {FRAC_BITS{1'b0}}} / span;
          step[i] = $signed({1'b0, mag});
        end else begin
          mag = {from_c - to_c, {FRAC_BITS{1'b0}}} / span;
          step[i] = -$signed({1'b0, mag});
        end
      end
    end else if (armed) begin
      if (running) begin
        nxt = {1'b0, frame_cnt} + 1'b1;
        if (nxt >= {1'b0, span}) begin
          frame_cnt = span;
          running = 1'b0;
        end else begin
          frame_cnt = nxt[COUNT_BITS-1:0];
        end
      end
      for (int i = 0; i < 4; i++) begin
        if (frame_cnt == span) begin
          level[i] = {end_rgb[CHAN_W*(3-i) +: CHAN_W], {FRAC_BITS{1'b0}}};
        end else begin
          sum = $signed({2'b00, level[i]}) + step[i];
          if (sum < 0) level[i] = '0;
          else if (sum > $signed({2'b00, LEVEL_MAX})) level[i] = LEVEL_MAX;
          else level[i] = sum[LEVEL_W-1:0];
        end
      end
    end
    view.alpha = level[0][LEVEL_W-1 -: CHAN_W];
    view.red = level[1][LEVEL_W-1 -: CHAN_W];
    view.green = level[2][LEVEL_W-1 -: CHAN_W];
    view.blue = level[3][LEVEL_W-1 -: CHAN_W];
    view.visible = armed;
    view.fading = running;
    if (span == 0) pct = 32'd100;
    else pct = (32'(frame_cnt) * 32'd100) / 32'(span);
    if (pct > 32'd100) pct = 32'd100;
    view.percent = pct[PCT_W-1:0];
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      fails++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    fade_view_t want;
    if (!rst_n) begin
      dur_reg = '0;
      start_reg = '0;
      target_reg = '0;
      frame_cnt = '0;
      span = '0;
      end_rgb = '0;
      armed = 1'b0;
      running = 1'b0;
      for (int i = 0; i < 4; i++) begin
        level[i] = '0;
        step[i] = '0;
      end
      due_views.delete();
      due_count <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_DURATION: dur_reg = cfg_wdata[DUR_W-1:0];
          REG_START:    start_reg = cfg_wdata;
          REG_TARGET:   target_reg = cfg_wdata;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (due_views.size() == 0) begin
          fails++;
          if (fails <= 50) $error("result beat with no expectation pending");
        end else begin
          want = due_views.pop_front();
          check_field("alpha_out", want.alpha, out_alpha_out);
          check_field("red_out", want.red, out_red_out);
          check_field("green_out", want.green, out_green_out);
          check_field("blue_out", want.blue, out_blue_out);
          check_field("visible", want.visible, out_visible);
          check_field("fading", want.fading, out_fading);
          check_field("progress_percent", want.percent, out_progress_percent);
        end
      end
      if (in_valid && !in_stall) begin
        advance_fade(in_start_fade, want);
        due_views.push_back(want);
      end
      due_count <= due_views.size();
    end
  end

endmodule

`default_nettype wire

// ===== bench/argb_linear_fade_ramp_tb.sv =====
`default_nettype none

module argb_linear_fade_ramp_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import afr_pkg::*;

  localparam int ITEMS     = 540;
  localparam int LIMIT     = 2000;
  localparam int HOLD_LONG = 300;
  localparam int TAIL      = 40;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 in_start_fade = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [CHAN_W-1:0]    out_alpha_out;
  logic [CHAN_W-1:0]    out_red_out;
  logic [CHAN_W-1:0]    out_green_out;
  logic [CHAN_W-1:0]    out_blue_out;
  logic                 out_visible;
  logic                 out_fading;
  logic [PCT_W-1:0]     out_progress_percent;
  logic                 cfg_we = 1'b0;
  logic [1:0]           cfg_index = REG_NONE;
  logic [ARGB_W-1:0]    cfg_wdata = '0;

  int fail_count;
  int due_count;
  int items_sent = 0;
  int send_calm = 0;
  int recv_calm = 0;
  int holds_asked = 0;
  int holds_done = 0;
  int quiet = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  argb_linear_fade_ramp u_top (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_start_fade        (in_start_fade),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_alpha_out        (out_alpha_out),
    .out_red_out          (out_red_out),
    .out_green_out        (out_green_out),
    .out_blue_out         (out_blue_out),
    .out_visible          (out_visible),
    .out_fading           (out_fading),
    .out_progress_percent (out_progress_percent),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata)
  );

  fade_monitor u_mon (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_start_fade        (in_start_fade),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_alpha_out        (out_alpha_out),
    .out_red_out          (out_red_out),
    .out_green_out        (out_green_out),
    .out_blue_out         (out_blue_out),
    .out_visible          (out_visible),
    .out_fading           (out_fading),
    .out_progress_percent (out_progress_percent),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .fail_count           (fail_count),
    .due_count            (due_count)
  );

  task automatic pick_wait(inout int calm, output int cycles);
    if (calm > 0) begin
      calm--;
      cycles = 0;
    end else if ($urandom_range(0, 19) == 0) begin
      calm = $urandom_range(10, 40);
      cycles = 0;
    end else begin
      cycles = $urandom_range(0, 7);
    end
  endtask

  task automatic send_beat(input logic start_bit);
    int gap;
    pick_wait(send_calm, gap);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_start_fade <= start_bit;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task automatic run_ticks(input int n);
    for (int k = 0; k < n; k++) send_beat(1'b0);
  endtask

  // drop valid and wait out every pending result
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (due_count != 0) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [ARGB_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  task automatic program_fade(input logic [3:0] which, input logic [DUR_W-1:0] dur,
                              input logic [ARGB_W-1:0] from_rgb,
                              input logic [ARGB_W-1:0] to_rgb);
    settle();
    if (which[0]) write_reg(REG_DURATION, ARGB_W'(dur));
    if (which[1]) write_reg(REG_START, from_rgb);
    if (which[2]) write_reg(REG_TARGET, to_rgb);
    if (which[3]) write_reg(REG_NONE, ARGB_W'($urandom));
    cfg_we <= 1'b0;
  endtask

  function automatic logic [ARGB_W-1:0] rand_color();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return ARGB_W'($urandom);
    endcase
  endfunction

  initial begin
    int w;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (holds_done != holds_asked) begin
        holds_done++;
        w = HOLD_LONG;
      end else begin
        pick_wait(recv_calm, w);
      end
      if (w != 0) begin
        out_stall <= 1'b1;
        repeat (w) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    logic [DUR_W-1:0] dur;
    int n;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // tick before any start
    send_beat(1'b0);

    // zero duration, plus a write to the unused index
    program_fade(4'b1111, '0, '1, '0);
    send_beat(1'b1);
    run_ticks(2);

    // short fade, target rewritten mid-fade, ticks past the end
    program_fade(4'b0111, 16'd4, 32'h00FF_00FF, 32'hFF00_FF00);
    send_beat(1'b1);
    run_ticks(2);
    program_fade(4'b0100, '0, '0, 32'h1234_5678);
    run_ticks(3);
    send_beat(1'b1);
    run_ticks(1);

    // longest duration, long receiver hold, restart mid-fade
    program_fade(4'b0111, '1, '0, '1);
    holds_asked++;
    send_beat(1'b1);
    run_ticks(3);
    send_beat(1'b1);
    run_ticks(1);

    // single-frame fade
    program_fade(4'b0001, 16'd1, '0, '0);
    send_beat(1'b1);
    run_ticks(2);

    while (items_sent < ITEMS) begin
      case ($urandom_range(0, 9))
        0: dur = '0;
        1: dur = 16'd1;
        2: dur = '1;
        3: dur = DUR_W'($urandom);
        default: dur = DUR_W'($urandom_range(2, 24));
      endcase
      program_fade(4'($urandom_range(0, 15)), dur, rand_color(), rand_color());
      if ($urandom_range(0, 11) == 0) holds_asked++;
      if ($urandom_range(0, 4) == 0) begin
        run_ticks($urandom_range(1, 5));
      end else begin
        send_beat(1'b1);
        n = (dur <= 40) ? $urandom_range(0, dur + 3) : $urandom_range(0, 12);
        for (int k = 0; k < n; k++) send_beat($urandom_range(0, 15) == 0);
      end
    end

    settle();
    repeat (TAIL) @(posedge clk);
    if (fail_count == 0 && due_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
hw/rtl/afr_pkg.sv
hw/rtl/afr_div.sv
hw/rtl/afr_dp.sv
hw/rtl/afr_ctrl.sv
hw/rtl/argb_linear_fade_ramp.sv
bench/fade_monitor.sv
bench/argb_linear_fade_ramp_tb.sv
